@@ sv/pwss_pkg.sv @@
// ----------------------------------------------------------------------------
// pwss_pkg
// Request and status codes and the case folding helper for the positional
// word similarity search.
// ----------------------------------------------------------------------------
package pwss_pkg;

	localparam logic [1:0] REQ_QUERY  = 2'd0;
	localparam logic [1:0] REQ_DICT   = 2'd1;
	localparam logic [1:0] REQ_FINISH = 2'd2;

	localparam logic [1:0] STAT_NONE    = 2'd0;
	localparam logic [1:0] STAT_CLOSEST = 2'd1;
	localparam logic [1:0] STAT_EXACT   = 2'd2;

	localparam logic [7:0] UPPER_A = 8'h41;
	localparam logic [7:0] UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	// Map ASCII upper case onto lower case, leave every other byte alone.
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if (c >= UPPER_A && c <= UPPER_Z) begin
			return c + CASE_OFFSET;
		end
		return c;
	endfunction

endpackage

@@ sv/pwss_in_if.sv @@
// ----------------------------------------------------------------------------
// pwss_in_if
// Request channel: query characters, dictionary characters and finish words.
// ----------------------------------------------------------------------------
interface pwss_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] char_code;
	logic       word_end;

	modport source (output valid, req_type, char_code, word_end, input ready);
	modport sink (input valid, req_type, char_code, word_end, output ready);
endinterface

@@ sv/pwss_out_if.sv @@
// ----------------------------------------------------------------------------
// pwss_out_if
// Result channel: one report word per finish request.
// ----------------------------------------------------------------------------
interface pwss_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] best_index;
	logic [6:0]  match_count;
	logic [6:0]  word_length;

	modport source (output valid, status, best_index, match_count, word_length,
		input ready);
	modport sink (input valid, status, best_index, match_count, word_length,
		output ready);
endinterface

@@ sv/pwss_ram.sv @@
// ----------------------------------------------------------------------------
// pwss_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pwss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ sv/positional_word_similarity_search_top.sv @@
// A finish word's report passes through stage 1 and then the result register.
// Throughput: one word per cycle while the sink is not stalling the result register;
// the query store read is registered, so the position counter runs at accept time and scoring happens in stage 1.
// Reset: asynchronous, clears all control and search state; the query store
// holds garbage until the first query is loaded and needs no clearing.
// ----------------------------------------------------------------------------
// positional_word_similarity_search_top
// Loads a query word, scores streamed dictionary words by case-insensitive
// positional matches over word length and reports the best or exact word.
// ----------------------------------------------------------------------------
module positional_word_similarity_search_top #(
	parameter int MAX_WORD_LEN = 64,
	parameter int MAX_WORDS    = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	pwss_in_if.sink     in_ch,
	pwss_out_if.source  out_ch
);
	import pwss_pkg::*;

	localparam int LW = $clog2(MAX_WORD_LEN + 1);
	localparam int AW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
	localparam int WW = $clog2(MAX_WORDS);
	localparam logic [LW-1:0] LEN_MAX  = LW'(MAX_WORD_LEN);
	localparam logic [WW-1:0] WORD_TOP = WW'(MAX_WORDS - 1);

	logic en, acc, start;

	// front end: runs at accept time
	logic          open_q;
	logic [LW-1:0] qlen_q;
	logic [LW-1:0] pos_q;
	logic [LW-1:0] qbase;

	// stage 1
	logic          valid_s1;
	logic [1:0]    req_s1;
	logic [7:0]    ch_s1;
	logic          last_s1;
	logic [LW-1:0] pos_s1;
	logic [LW-1:0] qlen_s1;
	logic          start_s1;

	// search state
	logic [LW-1:0] cur_m_q;
	logic          cur_id_q;
	logic [WW-1:0] wc_q;
	logic [WW-1:0] best_idx_q;
	logic [LW-1:0] best_m_q;
	logic [LW-1:0] best_len_q;
	logic          exact_q;

	// result register
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [15:0]   index_q;
	logic [6:0]    count_q;
	logic [6:0]    length_q;

	logic [7:0]      q_char;
	logic            in_rng, in_q, hit;
	logic [LW-1:0]   cur_m_nxt, len_nxt;
	logic            cur_id_nxt, is_exact, better;
	logic [2*LW-1:0] lhs, rhs;

	assign en    = !(out_valid_q && !out_ch.ready);
	assign acc   = in_ch.valid && en;
	assign start = !open_q;
	assign qbase = start ? '0 : qlen_q;

	assign in_ch.ready = en;

	pwss_ram #(
		.WIDTH (8),
		.DEPTH (MAX_WORD_LEN)
	) u_query_ram (
		.clk     (clk),
		.wr_en   (acc && in_ch.req_type == REQ_QUERY && qbase < LEN_MAX),
		.wr_addr (qbase[AW-1:0]),
		.wr_data (in_ch.char_code),
		.rd_en   (en),
		.rd_addr (pos_q[AW-1:0]),
		.rd_data (q_char)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			qlen_q <= '0;
			pos_q  <= '0;
		end else if (acc) begin
			unique case (in_ch.req_type)
				REQ_QUERY: begin
					open_q <= !in_ch.word_end;
					pos_q  <= '0;
					if (qbase < LEN_MAX) begin
						qlen_q <= qbase + 1'b1;
					end else begin
						qlen_q <= qbase;
					end
				end
				REQ_DICT: begin
					open_q <= 1'b0;
					if (in_ch.word_end) begin
						pos_q <= '0;
					end else if (pos_q < LEN_MAX) begin
						pos_q <= pos_q + 1'b1;
					end
				end
				REQ_FINISH: begin
					open_q <= 1'b0;
					pos_q  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_s1   <= in_ch.req_type;
			ch_s1    <= in_ch.char_code;
			last_s1  <= in_ch.word_end;
			pos_s1   <= pos_q;
			qlen_s1  <= qlen_q;
			start_s1 <= start;
		end
	end

	// score one dictionary word
	always_comb begin
		in_rng     = pos_s1 < LEN_MAX;
		in_q       = pos_s1 < qlen_s1;
		hit        = in_rng && in_q && (fold_case(q_char) == fold_case(ch_s1));
		cur_m_nxt  = cur_m_q + LW'(hit);
		cur_id_nxt = cur_id_q && !(in_rng && (!in_q || q_char != ch_s1));
		len_nxt    = in_rng ? pos_s1 + 1'b1 : pos_s1;
		is_exact   = cur_id_nxt && (len_nxt == qlen_s1);
		lhs        = (2*LW)'(cur_m_nxt) * (2*LW)'(best_len_q);
		rhs        = (2*LW)'(best_m_q) * (2*LW)'(len_nxt);
		better     = lhs > rhs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_m_q    <= '0;
			cur_id_q   <= 1'b1;
			wc_q       <= '0;
			best_idx_q <= '0;
			best_m_q   <= '0;
			best_len_q <= LW'(1);
			exact_q    <= 1'b0;
		end else if (en && valid_s1) begin
			unique case (req_s1)
				REQ_QUERY: begin
					if (start_s1) begin
						cur_m_q    <= '0;
						cur_id_q   <= 1'b1;
						wc_q       <= '0;
						best_idx_q <= '0;
						best_m_q   <= '0;
						best_len_q <= LW'(1);
						exact_q    <= 1'b0;
					end
				end
				REQ_DICT: begin
					if (!exact_q) begin
						if (last_s1) begin
							priority if (is_exact) begin
								exact_q    <= 1'b1;
								best_idx_q <= wc_q;
								best_m_q   <= len_nxt;
								best_len_q <= len_nxt;
							end else if (better) begin
								best_idx_q <= wc_q;
								best_m_q   <= cur_m_nxt;
								best_len_q <= len_nxt;
							end else begin
							end
							wc_q     <= (wc_q == WORD_TOP) ? '0 : wc_q + 1'b1;
							cur_m_q  <= '0;
							cur_id_q <= 1'b1;
						end else begin
							cur_m_q  <= cur_m_nxt;
							cur_id_q <= cur_id_nxt;
						end
					end
				end
				REQ_FINISH: begin
					cur_m_q    <= '0;
					cur_id_q   <= 1'b1;
					wc_q       <= '0;
					best_idx_q <= '0;
					best_m_q   <= '0;
					best_len_q <= LW'(1);
					exact_q    <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// report word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s1 && req_s1 == REQ_FINISH;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1 && req_s1 == REQ_FINISH) begin
			priority if (exact_q) begin
				status_q <= STAT_EXACT;
				index_q  <= 16'(best_idx_q);
				count_q  <= 7'(best_m_q);
				length_q <= 7'(best_len_q);
			end else if (best_m_q == '0) begin
				status_q <= STAT_NONE;
				index_q  <= '0;
				count_q  <= '0;
				length_q <= '0;
			end else begin
				status_q <= STAT_CLOSEST;
				index_q  <= 16'(best_idx_q);
				count_q  <= 7'(best_m_q);
				length_q <= 7'(best_len_q);
			end
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = status_q;
	assign out_ch.best_index  = index_q;
	assign out_ch.match_count = count_q;
	assign out_ch.word_length = length_q;

endmodule

@@ dv/tb_positional_word_similarity_search_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_word_similarity_search_top
// Streams query words, dictionary words and finish requests into the search
// block. A scoring model inside the bench predicts every report, and each
// report the block returns is compared with it, field by field, in order.
// ----------------------------------------------------------------------------
module tb_positional_word_similarity_search_top;
	import pwss_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int WORD_CAP = 64;
	localparam int RANDOM_WORDS = 1950;

	typedef struct packed {
		logic [1:0] req;
		logic [7:0] ch;
		logic       last;
	} search_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] index;
		logic [6:0]  hits;
		logic [6:0]  len;
	} search_report_t;

	typedef bit [7:0] byte_q_t[$];

	logic clk;
	logic arst_n;

	pwss_in_if  in_ch ();
	pwss_out_if out_ch ();

	positional_word_similarity_search_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	search_word_t   words_to_send[$];
	search_report_t reports_due[$];

	// scoring model state
	bit [7:0]    query_chars[WORD_CAP];
	int unsigned query_len;
	bit          query_open;
	int unsigned cur_pos;
	int unsigned cur_hits;
	bit          cur_same;
	bit [15:0]   word_idx;
	bit [15:0]   best_idx;
	int unsigned best_hits;
	int unsigned best_len;
	bit          exact_hit;

	int unsigned stim_count;
	int unsigned words_taken;
	int unsigned reports_checked;
	int unsigned mismatches;
	int unsigned n_exact;
	int unsigned n_closest;
	int unsigned n_none;

	bit          in_fired;
	bit          calm;
	int unsigned in_gap;
	int unsigned out_gap;
	int unsigned in_idle_pct;
	int unsigned out_idle_pct;

	byte_q_t search_query;

	function automatic bit [7:0] lower_ascii(input bit [7:0] c);
		return (c inside {[8'h41:8'h5A]}) ? (c | 8'h20) : c;
	endfunction

	task automatic clear_search();
		cur_pos = 0;
		cur_hits = 0;
		cur_same = 1'b1;
		word_idx = '0;
		best_idx = '0;
		best_hits = 0;
		best_len = 1;
		exact_hit = 1'b0;
	endtask

	task automatic search_step(input search_word_t it);
		search_report_t rep;
		case (it.req)
			REQ_QUERY: begin
				if (!query_open) begin
					query_len = 0;
					clear_search();
					query_open = 1'b1;
				end
				if (query_len < WORD_CAP) begin
					query_chars[query_len] = it.ch;
					query_len++;
				end
				if (it.last) begin
					query_open = 1'b0;
				end
			end
			REQ_DICT: begin
				query_open = 1'b0;
				if (!exact_hit) begin
					// drop characters past the length bound
					if (cur_pos < WORD_CAP) begin
						if (cur_pos < query_len) begin
							if (lower_ascii(query_chars[cur_pos]) == lower_ascii(it.ch)) begin
								cur_hits++;
							end
							if (query_chars[cur_pos] != it.ch) begin
								cur_same = 1'b0;
							end
						end else begin
							cur_same = 1'b0;
						end
						cur_pos++;
					end
					if (it.last) begin
						if (cur_same && cur_pos == query_len) begin
							exact_hit = 1'b1;
							best_idx = word_idx;
							best_hits = cur_pos;
							best_len = cur_pos;
						end else if (cur_hits * best_len > best_hits * cur_pos) begin
							best_idx = word_idx;
							best_hits = cur_hits;
							best_len = cur_pos;
						end
						word_idx++;
						cur_pos = 0;
						cur_hits = 0;
						cur_same = 1'b1;
					end
				end
			end
			REQ_FINISH: begin
				query_open = 1'b0;
				if (exact_hit) begin
					rep = '{STAT_EXACT, best_idx, best_hits[6:0], best_len[6:0]};
					n_exact++;
				end else if (best_hits == 0) begin
					rep = '{STAT_NONE, 16'd0, 7'd0, 7'd0};
					n_none++;
				end else begin
					rep = '{STAT_CLOSEST, best_idx, best_hits[6:0], best_len[6:0]};
					n_closest++;
				end
				reports_due.push_back(rep);
				clear_search();
			end
			default: begin
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// stimulus construction
	// ------------------------------------------------------------------
	task automatic add_item(input logic [1:0] req, input bit [7:0] ch, input bit last);
		words_to_send.push_back('{req, ch, last});
		if (req != REQ_UNUSED) begin
			stim_count++;
		end
	endtask

	task automatic push_word(input logic [1:0] req, input byte_q_t chars, input bit close);
		foreach (chars[i]) begin
			add_item(req, chars[i], close && (i == chars.size() - 1));
		end
	endtask

	function automatic byte_q_t text(input string s);
		byte_q_t q;
		for (int i = 0; i < s.len(); i++) begin
			q.push_back(s[i]);
		end
		return q;
	endfunction

	function automatic bit [7:0] rand_char();
		bit [7:0] c;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				c = 8'h61 + 8'($urandom_range(0, 3));
				if ($urandom_range(0, 1)) c = c ^ 8'h20;
			end
			6, 7: begin
				c = (8'h41 + 8'($urandom_range(0, 25))) |
					($urandom_range(0, 1) ? 8'h20 : 8'h00);
			end
			8: begin
				// bytes just outside the letter ranges
				case ($urandom_range(0, 3))
					0: c = 8'h40;
					1: c = 8'h5B;
					2: c = 8'h60;
					default: c = 8'h7B;
				endcase
			end
			default: c = 8'($urandom_range(0, 255));
		endcase
		return c;
	endfunction

	function automatic int unsigned pick_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 85) return $urandom_range(1, 8);
		if (r < 95) return $urandom_range(9, 40);
		return $urandom_range(60, 70);
	endfunction

	function automatic byte_q_t make_word(input byte_q_t q);
		byte_q_t w;
		int unsigned n;
		case ($urandom_range(0, 9))
			0, 1: w = q;
			2, 3: begin
				w = q;
				foreach (w[i]) begin
					if (lower_ascii(w[i]) inside {[8'h61:8'h7A]} && $urandom_range(0, 1)) begin
						w[i] = w[i] ^ 8'h20;
					end
				end
			end
			4, 5, 6: begin
				w = q;
				n = $urandom_range(0, 2);
				repeat (n) begin
					if (w.size() != 0) w[$urandom_range(0, w.size() - 1)] = rand_char();
				end
				case ($urandom_range(0, 2))
					0: begin
						n = $urandom_range(1, 3);
						repeat (n) if (w.size() > 1) void'(w.pop_back());
					end
					1: begin
						n = $urandom_range(1, 3);
						repeat (n) w.push_back(rand_char());
					end
					default: begin
					end
				endcase
			end
			default: begin
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
				repeat (n) w.push_back(rand_char());
			end
		endcase
		if (w.size() == 0) w.push_back(rand_char());
		return w;
	endfunction

	task automatic random_search();
		byte_q_t w;
		int unsigned n;
		if (search_query.size() == 0 || $urandom_range(0, 4) != 0) begin
			search_query.delete();
			n = pick_len();
			repeat (n) search_query.push_back(rand_char());
			// sometimes leave the query open so the first dictionary word closes it
			push_word(REQ_QUERY, search_query, $urandom_range(0, 9) != 0);
		end
		n = $urandom_range(0, 8);
		repeat (n) begin
			if ($urandom_range(0, 24) == 0) begin
				add_item(REQ_UNUSED, rand_char(), 1'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 39) == 0) begin
				// restart the query mid-stream
				search_query.delete();
				search_query.push_back(rand_char());
				push_word(REQ_QUERY, search_query, 1'b1);
			end
			w = make_word(search_query);
			push_word(REQ_DICT, w, 1'b1);
		end
		if ($urandom_range(0, 9) == 0) begin
			w = make_word(search_query);
			push_word(REQ_DICT, w, 1'b0);
		end
		add_item(REQ_FINISH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	function automatic int unsigned pick_idle();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 10;
			default: return 35;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// clock, watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// driver and report sink, both change at the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (in_ch.valid && !in_fired) begin
			// hold the word until it is taken
		end else if (in_gap != 0) begin
			in_gap <= in_gap - 1;
			in_ch.valid <= 1'b0;
		end else if (!calm && words_to_send.size() != 0 &&
				$urandom_range(0, 99) < in_idle_pct) begin
			in_gap <= $urandom_range(0, 5);
			in_ch.valid <= 1'b0;
		end else if (words_to_send.size() != 0) begin
			in_ch.valid <= 1'b1;
			in_ch.req_type <= words_to_send[0].req;
			in_ch.char_code <= words_to_send[0].ch;
			in_ch.word_end <= words_to_send[0].last;
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (out_gap != 0) begin
			out_gap <= out_gap - 1;
			out_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < out_idle_pct) begin
			out_gap <= $urandom_range(0, 5);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	task automatic check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 40) begin
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// monitor and prediction at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin : sample
		search_report_t want;
		in_fired <= arst_n && in_ch.valid && in_ch.ready;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (reports_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 40) begin
						$display("%0t: unexpected report: expected none, got status %0d index %0d",
							$time, out_ch.status, out_ch.best_index);
					end
				end else begin
					want = reports_due.pop_front();
					check_field("status", want.status, out_ch.status);
					check_field("best_index", want.index, out_ch.best_index);
					check_field("match_count", want.hits, out_ch.match_count);
					check_field("word_length", want.len, out_ch.word_length);
					reports_checked++;
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				search_step(words_to_send.pop_front());
				words_taken++;
				if (words_taken % 400 == 0) begin
					in_idle_pct = pick_idle();
					out_idle_pct = pick_idle();
				end
			end
			// no idling over the tail of the run
			calm = (words_to_send.size() < 250);
		end
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------
	initial begin : stimulus
		int unsigned random_base;

		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.req_type = REQ_QUERY;
		in_ch.char_code = 8'h00;
		in_ch.word_end = 1'b0;
		out_ch.ready = 1'b0;
		in_fired = 1'b0;
		calm = 1'b0;
		in_gap = 0;
		out_gap = 0;
		in_idle_pct = 10;
		out_idle_pct = 10;
		query_len = 0;
		query_open = 1'b0;
		clear_search();

		// case-insensitive hit, a tie that must not win, exact latch, ignored word
		push_word(REQ_QUERY, text("Cat"), 1'b1);
		push_word(REQ_DICT, text("cat"), 1'b1);
		push_word(REQ_DICT, text("Ca"), 1'b1);
		push_word(REQ_DICT, text("Cat"), 1'b1);
		push_word(REQ_DICT, text("x"), 1'b1);
		add_item(REQ_FINISH, 8'hFF, 1'b1);
		// empty search, then an unfinished word that must be discarded
		add_item(REQ_FINISH, 8'h00, 1'b0);
		push_word(REQ_DICT, text("ca"), 1'b0);
		add_item(REQ_UNUSED, 8'hFF, 1'b1);
		add_item(REQ_FINISH, 8'h00, 1'b0);
		// byte extremes; the dictionary word closes the open query
		add_item(REQ_QUERY, 8'h00, 1'b0);
		add_item(REQ_QUERY, 8'hFF, 1'b0);
		add_item(REQ_DICT, 8'h00, 1'b0);
		add_item(REQ_DICT, 8'hFF, 1'b1);
		add_item(REQ_FINISH, 8'h5A, 1'b1);

		search_query = text("ab");
		random_base = stim_count;
		while (stim_count - random_base < RANDOM_WORDS) begin
			random_search();
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (words_to_send.size() != 0 || reports_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (16) @(posedge clk);

		$display("Sent %0d words; checked %0d reports (%0d exact, %0d closest, %0d none).",
			words_taken, reports_checked, n_exact, n_closest, n_none);
		$display("Mismatches: %0d", mismatches);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
